### src/pts_pkg.sv
// Shared types, codes and helpers for the priority task scheduler.
// No dependencies; every other file imports this package.
package pts_pkg;

    localparam int ID_W    = 10;
    localparam int PRIO_W  = 6;
    localparam int STAMP_W = 32;
    localparam int TICK_W  = 32;
    localparam int SLICE_W = 8;
    localparam int KEY_W   = PRIO_W + STAMP_W;

    typedef enum logic [2:0] {
        REQ_MAKE_READY = 3'd0,
        REQ_YIELD      = 3'd1,
        REQ_BLOCK      = 3'd2,
        REQ_SLEEP      = 3'd3,
        REQ_TICK       = 3'd4,
        REQ_EXIT       = 3'd5,
        REQ_SET_PRIO   = 3'd6,
        REQ_UNUSED     = 3'd7
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_INVAL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_ROT    = 2'd3
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        logic      keep;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_YINS = 2'd1,
        ST_SCAN = 2'd2,
        ST_DONE = 2'd3
    } sched_state_t;

    // Priority order: higher priority first, older stamp first on a tie.
    function automatic logic goes_before(input logic [PRIO_W-1:0] pa,
                                         input logic [STAMP_W-1:0] sa,
                                         input logic [PRIO_W-1:0] pb,
                                         input logic [STAMP_W-1:0] sb);
        logic r;
        if (pa == pb) begin
            r = (sa < sb);
        end else begin
            r = (pa > pb);
        end
        return r;
    endfunction

endpackage

### src/pts_cell.sv
// One slot of a sorted store: holds an entry keyed by {prio, stamp}.
// Depends on pts_pkg; instantiated by pts_chain.
module pts_cell import pts_pkg::*; #(
    parameter int IDX    = 0,
    parameter int DATA_W = 10,
    parameter int CNT_W  = 5
) (
    input  logic                    aclk,
    input  chain_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]        fill,
    input  logic [CNT_W-1:0]        tail,
    input  logic [KEY_W+DATA_W-1:0] new_ent,
    input  logic [KEY_W+DATA_W-1:0] left_ent,
    input  logic [KEY_W+DATA_W-1:0] right_ent,
    input  logic                    left_after,
    output logic [KEY_W+DATA_W-1:0] ent,
    output logic                    after
);

    localparam int W = KEY_W + DATA_W;

    logic [W-1:0] ent_reg;
    logic [W-1:0] ent_next;
    logic         valid;

    assign valid = (CNT_W'(IDX) < fill);
    // New entry goes behind this one when it does not outrank it.
    assign after = valid && !goes_before(new_ent[W-1 -: PRIO_W],
                                         new_ent[W-PRIO_W-1 -: STAMP_W],
                                         ent_reg[W-1 -: PRIO_W],
                                         ent_reg[W-PRIO_W-1 -: STAMP_W]);

    always_comb begin
        unique case (ctrl.op)
            OP_HOLD: begin
                ent_next = ent_reg;
            end
            OP_INSERT: begin
                if (after) begin
                    ent_next = ent_reg;
                end else if (left_after) begin
                    ent_next = new_ent;
                end else begin
                    ent_next = left_ent;
                end
            end
            OP_POP: begin
                ent_next = right_ent;
            end
            OP_ROT: begin
                // advance toward the head; a kept head re-enters at the tail
                if (ctrl.keep && (CNT_W'(IDX) == tail)) begin
                    ent_next = new_ent;
                end else begin
                    ent_next = right_ent;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

### src/pts_chain.sv
// Row of pts_cell slots forming one sorted store with insert, pop and rotate.
// Depends on pts_pkg and pts_cell.
module pts_chain import pts_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 10,
    parameter int CNT_W  = 5
) (
    input  logic                    aclk,
    input  chain_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]        fill,
    input  logic [KEY_W+DATA_W-1:0] new_ent,
    output logic [KEY_W+DATA_W-1:0] head
);

    localparam int W = KEY_W + DATA_W;

    logic [W-1:0]     ents  [DEPTH];
    logic             afts  [DEPTH];
    logic [CNT_W-1:0] tail;

    assign tail = fill - CNT_W'(1);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [W-1:0] left_e;
        logic [W-1:0] right_e;
        logic         left_a;
        if (i == 0) begin : g_first
            assign left_e = new_ent;
            assign left_a = 1'b1;
        end else begin : g_mid
            assign left_e = ents[i-1];
            assign left_a = afts[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_e = ents[i];
        end else begin : g_inner
            assign right_e = ents[i+1];
        end
        pts_cell #(.IDX(i), .DATA_W(DATA_W), .CNT_W(CNT_W)) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .fill       (fill),
            .tail       (tail),
            .new_ent    (new_ent),
            .left_ent   (left_e),
            .right_ent  (right_e),
            .left_after (left_a),
            .ent        (ents[i]),
            .after      (afts[i])
        );
    end

    assign head = ents[0];

endmodule

### src/priority_task_scheduler.sv
// Priority task scheduler: sorted ready store and sleep store built as cell chains.
// Depends on pts_pkg and pts_chain.
//
// One request is taken when the block is idle and answered with one result.
// make_ready, block, exit, sleep, the unused code, and yield or set_priority
// without a reinsert go from accept through the done state back to idle. yield
// and set_priority that reinsert the old task also pass the reinsert state, since
// the reinsert is a second insert step of the ready chain after the head pop. tick
// runs the scan state, where the sleep chain rotates one sleeper past the wake
// compare per cycle over the sleepers held before the tick. A result that is not
// taken holds the block in its done state until the result register frees.
// A new request is taken while the previous result still waits on the output register.
module priority_task_scheduler import pts_pkg::*; #(
    parameter int READY_DEPTH = 16,
    parameter int SLEEP_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // slice length in ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,       // task_id, prio_level, birth_stamp, tick_value
    input  logic [2:0]  s_tuser,       // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // run_id, run_idle, switched, preempt_req,
                                       // status, ready_count, sleep_count, zero pad
);

    localparam int RC_W = $clog2(READY_DEPTH + 1);
    localparam int SC_W = $clog2(SLEEP_DEPTH + 1);
    localparam int RD_W = ID_W;
    localparam int SD_W = TICK_W + ID_W;
    localparam int RW   = KEY_W + RD_W;
    localparam int SW   = KEY_W + SD_W;

    sched_state_t state_reg, state_next;

    logic [RC_W-1:0]    rfill_reg, rfill_next;
    logic [SC_W-1:0]    sfill_reg, sfill_next;
    logic [SC_W-1:0]    scan_reg, scan_next;
    logic [ID_W-1:0]    cur_id_reg, cur_id_next;
    logic [PRIO_W-1:0]  cur_prio_reg, cur_prio_next;
    logic [STAMP_W-1:0] cur_stamp_reg, cur_stamp_next;
    logic               cur_idle_reg, cur_idle_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [SLICE_W-1:0] tslice_reg;
    logic [ID_W-1:0]    tmp_id_reg, tmp_id_next;
    logic [PRIO_W-1:0]  tmp_prio_reg, tmp_prio_next;
    logic [STAMP_W-1:0] tmp_stamp_reg, tmp_stamp_next;
    logic [TICK_W-1:0]  tv_reg, tv_next;
    logic               sw_reg, sw_next;
    logic               pre_reg, pre_next;
    status_t            status_reg, status_next;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    chain_ctrl_t  rctrl, sctrl;
    logic [RW-1:0] rnew, rhead;
    logic [SW-1:0] snew, shead;
    logic          yins_need;

    req_type_t          req;
    logic [ID_W-1:0]    in_id;
    logic [PRIO_W-1:0]  in_prio;
    logic [STAMP_W-1:0] in_stamp;
    logic [TICK_W-1:0]  in_tick;
    logic               s_acc;
    logic               out_free;
    logic               rfull, sfull;

    logic [PRIO_W-1:0]  rh_prio, sh_prio;
    logic [STAMP_W-1:0] rh_stamp, sh_stamp;
    logic [ID_W-1:0]    rh_id, sh_id;
    logic [TICK_W-1:0]  sh_wake;

    assign req      = req_type_t'(s_tuser);
    assign in_id    = s_tdata[9:0];
    assign in_prio  = s_tdata[15:10];
    assign in_stamp = s_tdata[47:16];
    assign in_tick  = s_tdata[79:48];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rfull    = (rfill_reg == RC_W'(READY_DEPTH));
    assign sfull    = (sfill_reg == SC_W'(SLEEP_DEPTH));

    assign rh_prio  = rhead[RW-1 -: PRIO_W];
    assign rh_stamp = rhead[RW-PRIO_W-1 -: STAMP_W];
    assign rh_id    = rhead[ID_W-1:0];
    assign sh_prio  = shead[SW-1 -: PRIO_W];
    assign sh_stamp = shead[SW-PRIO_W-1 -: STAMP_W];
    assign sh_wake  = shead[SD_W-1 -: TICK_W];
    assign sh_id    = shead[ID_W-1:0];

    pts_chain #(.DEPTH(READY_DEPTH), .DATA_W(RD_W), .CNT_W(RC_W)) u_ready (
        .aclk    (aclk),
        .ctrl    (rctrl),
        .fill    (rfill_reg),
        .new_ent (rnew),
        .head    (rhead)
    );

    pts_chain #(.DEPTH(SLEEP_DEPTH), .DATA_W(SD_W), .CNT_W(SC_W)) u_sleep (
        .aclk    (aclk),
        .ctrl    (sctrl),
        .fill    (sfill_reg),
        .new_ent (snew),
        .head    (shead)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (req == REQ_TICK) begin
                        state_next = ST_SCAN;
                    end else if (yins_need) begin
                        state_next = ST_YINS;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_YINS: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath control
    always_comb begin
        rfill_next     = rfill_reg;
        sfill_next     = sfill_reg;
        scan_next      = scan_reg;
        cur_id_next    = cur_id_reg;
        cur_prio_next  = cur_prio_reg;
        cur_stamp_next = cur_stamp_reg;
        cur_idle_next  = cur_idle_reg;
        slice_next     = slice_reg;
        tmp_id_next    = tmp_id_reg;
        tmp_prio_next  = tmp_prio_reg;
        tmp_stamp_next = tmp_stamp_reg;
        tv_next        = tv_reg;
        sw_next        = sw_reg;
        pre_next       = pre_reg;
        status_next    = status_reg;
        yins_need      = 1'b0;
        rctrl          = '{op: OP_HOLD, keep: 1'b0};
        sctrl          = '{op: OP_HOLD, keep: 1'b0};
        rnew           = {in_prio, in_stamp, in_id};
        snew           = {cur_prio_reg, cur_stamp_reg, in_tick, cur_id_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    sw_next     = 1'b0;
                    pre_next    = 1'b0;
                    status_next = STAT_OK;
                    tv_next     = in_tick;
                    unique case (req)
                        REQ_MAKE_READY: begin
                            if (rfull) begin
                                status_next = STAT_FULL;
                            end else begin
                                rctrl.op   = OP_INSERT;
                                rfill_next = rfill_reg + RC_W'(1);
                                pre_next   = cur_idle_reg || (in_prio > cur_prio_reg);
                            end
                        end
                        REQ_YIELD: begin
                            slice_next = '0;
                            if (rfill_reg != '0) begin
                                if (cur_idle_reg) begin
                                    rctrl.op       = OP_POP;
                                    rfill_next     = rfill_reg - RC_W'(1);
                                    cur_id_next    = rh_id;
                                    cur_prio_next  = rh_prio;
                                    cur_stamp_next = rh_stamp;
                                    cur_idle_next  = 1'b0;
                                    sw_next        = 1'b1;
                                end else if (!goes_before(cur_prio_reg, cur_stamp_reg,
                                                          rh_prio, rh_stamp)) begin
                                    rctrl.op       = OP_POP;
                                    rfill_next     = rfill_reg - RC_W'(1);
                                    tmp_id_next    = cur_id_reg;
                                    tmp_prio_next  = cur_prio_reg;
                                    tmp_stamp_next = cur_stamp_reg;
                                    cur_id_next    = rh_id;
                                    cur_prio_next  = rh_prio;
                                    cur_stamp_next = rh_stamp;
                                    sw_next        = 1'b1;
                                    yins_need      = 1'b1;
                                end
                            end
                        end
                        REQ_BLOCK, REQ_EXIT, REQ_SLEEP: begin
                            if (cur_idle_reg) begin
                                status_next = STAT_INVAL;
                            end else if ((req == REQ_SLEEP) && sfull) begin
                                status_next = STAT_FULL;
                            end else begin
                                if (req == REQ_SLEEP) begin
                                    sctrl.op   = OP_INSERT;
                                    sfill_next = sfill_reg + SC_W'(1);
                                end
                                slice_next = '0;
                                sw_next    = 1'b1;
                                if (rfill_reg == '0) begin
                                    cur_idle_next = 1'b1;
                                end else begin
                                    rctrl.op       = OP_POP;
                                    rfill_next     = rfill_reg - RC_W'(1);
                                    cur_id_next    = rh_id;
                                    cur_prio_next  = rh_prio;
                                    cur_stamp_next = rh_stamp;
                                end
                            end
                        end
                        REQ_TICK: begin
                            scan_next = sfill_reg;
                            if (slice_reg != '1) begin
                                slice_next = slice_reg + SLICE_W'(1);
                            end
                        end
                        REQ_SET_PRIO: begin
                            if (cur_idle_reg) begin
                                status_next = STAT_INVAL;
                            end else begin
                                cur_prio_next = in_prio;
                                // a higher head always wins the yield
                                if ((rfill_reg != '0) && (rh_prio > in_prio)) begin
                                    rctrl.op       = OP_POP;
                                    rfill_next     = rfill_reg - RC_W'(1);
                                    tmp_id_next    = cur_id_reg;
                                    tmp_prio_next  = in_prio;
                                    tmp_stamp_next = cur_stamp_reg;
                                    cur_id_next    = rh_id;
                                    cur_prio_next  = rh_prio;
                                    cur_stamp_next = rh_stamp;
                                    slice_next     = '0;
                                    sw_next        = 1'b1;
                                    yins_need      = 1'b1;
                                end
                            end
                        end
                        REQ_UNUSED: begin
                        end
                    endcase
                end
            end
            ST_YINS: begin
                rnew       = {tmp_prio_reg, tmp_stamp_reg, tmp_id_reg};
                rctrl.op   = OP_INSERT;
                rfill_next = rfill_reg + RC_W'(1);
            end
            ST_SCAN: begin
                rnew = {sh_prio, sh_stamp, sh_id};
                snew = shead;
                if (scan_reg != '0) begin
                    scan_next = scan_reg - SC_W'(1);
                    sctrl.op  = OP_ROT;
                    if ((sh_wake <= tv_reg) && !rfull) begin
                        // wake: move the head sleeper into the ready store
                        rctrl.op   = OP_INSERT;
                        rfill_next = rfill_reg + RC_W'(1);
                        sfill_next = sfill_reg - SC_W'(1);
                        if (!cur_idle_reg && (sh_prio > cur_prio_reg)) begin
                            pre_next = 1'b1;
                        end
                    end else begin
                        sctrl.keep = 1'b1;
                        if (sh_wake <= tv_reg) begin
                            status_next = STAT_FULL;
                        end
                    end
                end else begin
                    if ((cur_idle_reg && (rfill_reg != '0)) || (slice_reg >= tslice_reg)) begin
                        pre_next = 1'b1;
                    end
                end
            end
            ST_DONE: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rfill_reg     <= '0;
            sfill_reg     <= '0;
            scan_reg      <= '0;
            cur_id_reg    <= '0;
            cur_prio_reg  <= '0;
            cur_stamp_reg <= '0;
            cur_idle_reg  <= 1'b1;
            slice_reg     <= '0;
            tslice_reg    <= SLICE_W'(4);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rfill_reg     <= rfill_next;
            sfill_reg     <= sfill_next;
            scan_reg      <= scan_next;
            cur_id_reg    <= cur_id_next;
            cur_prio_reg  <= cur_prio_next;
            cur_stamp_reg <= cur_stamp_next;
            cur_idle_reg  <= cur_idle_next;
            slice_reg     <= slice_next;
            if (cfg_we) begin
                tslice_reg <= cfg_wdata;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tmp_id_reg    <= tmp_id_next;
        tmp_prio_reg  <= tmp_prio_next;
        tmp_stamp_reg <= tmp_stamp_next;
        tv_reg        <= tv_next;
        sw_reg        <= sw_next;
        pre_reg       <= pre_next;
        status_reg    <= status_next;
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {7'd0,
                            5'(sfill_reg),
                            5'(rfill_reg),
                            status_reg,
                            pre_reg,
                            sw_reg,
                            cur_idle_reg,
                            cur_idle_reg ? {ID_W{1'b0}} : cur_id_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_rfill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rfill_reg <= RC_W'(READY_DEPTH))
        else $error("ready fill above depth");

    a_sfill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sfill_reg <= SC_W'(SLEEP_DEPTH))
        else $error("sleep fill above depth");

    a_scan_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> (rfill_reg >= $past(rfill_reg)))
        else $error("ready store shrank during wake scan");

    a_scan_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=>
            ((rfill_reg + RC_W'(sfill_reg)) ==
             ($past(rfill_reg) + RC_W'($past(sfill_reg)))))
        else $error("wake scan lost or invented a task");

    a_yins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_YINS) |-> (rfill_reg != RC_W'(READY_DEPTH)))
        else $error("reinsert with a full ready store");

endmodule

### tb/sv/priority_task_scheduler_tb.sv
// Testbench for the priority task scheduler: drives scheduler requests on the
// input stream, predicts each answer in a local model and checks it field by field.
// Depends on pts_pkg and the priority_task_scheduler RTL.
`timescale 1ns / 100ps

module priority_task_scheduler_tb;
    import pts_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [9:0] run_id;
        logic       run_idle;
        logic       switched;
        logic       preempt_req;
        logic [1:0] status;
        logic [4:0] ready_count;
        logic [4:0] sleep_count;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    priority_task_scheduler dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // scheduler model state
    logic [9:0]  rdy_id [DEPTH];
    logic [5:0]  rdy_pr [DEPTH];
    logic [31:0] rdy_st [DEPTH];
    int          rdy_n;
    logic [9:0]  slp_id [DEPTH];
    logic [5:0]  slp_pr [DEPTH];
    logic [31:0] slp_st [DEPTH];
    logic [31:0] slp_wk [DEPTH];
    int          slp_n;
    logic [9:0]  cur_id;
    logic [5:0]  cur_pr;
    logic [31:0] cur_st;
    logic        cur_idle;
    logic [7:0]  slice_cnt;
    logic [7:0]  slice_len;

    answer_t answer_q[$];
    int  fail_cnt = 0;
    int  answers_seen = 0;
    int  idle_cnt = 0;
    int  idle_pct = 33;
    bit  rx_hold = 0;
    logic [31:0] now_tick = 0;

    function automatic bit ranks_ahead(logic [5:0] pa, logic [31:0] sa,
                                       logic [5:0] pb, logic [31:0] sb);
        if (pa == pb) return sa < sb;
        return pa > pb;
    endfunction

    function automatic bit ready_push(logic [9:0] id, logic [5:0] pr, logic [31:0] st);
        int p;
        p = 0;
        if (rdy_n >= DEPTH) return 0;
        while (p < rdy_n && !ranks_ahead(pr, st, rdy_pr[p], rdy_st[p])) p++;
        for (int i = rdy_n; i > p; i--) begin
            rdy_id[i] = rdy_id[i-1]; rdy_pr[i] = rdy_pr[i-1]; rdy_st[i] = rdy_st[i-1];
        end
        rdy_id[p] = id; rdy_pr[p] = pr; rdy_st[p] = st;
        rdy_n++;
        return 1;
    endfunction

    function automatic bit sleep_push(logic [31:0] wk);
        int p;
        p = 0;
        if (slp_n >= DEPTH) return 0;
        while (p < slp_n && !ranks_ahead(cur_pr, cur_st, slp_pr[p], slp_st[p])) p++;
        for (int i = slp_n; i > p; i--) begin
            slp_id[i] = slp_id[i-1]; slp_pr[i] = slp_pr[i-1];
            slp_st[i] = slp_st[i-1]; slp_wk[i] = slp_wk[i-1];
        end
        slp_id[p] = cur_id; slp_pr[p] = cur_pr; slp_st[p] = cur_st; slp_wk[p] = wk;
        slp_n++;
        return 1;
    endfunction

    function automatic void dispatch_head();
        slice_cnt = 0;
        if (rdy_n == 0) begin
            cur_idle = 1;
            return;
        end
        cur_idle = 0;
        cur_id = rdy_id[0]; cur_pr = rdy_pr[0]; cur_st = rdy_st[0];
        for (int i = 1; i < rdy_n; i++) begin
            rdy_id[i-1] = rdy_id[i]; rdy_pr[i-1] = rdy_pr[i]; rdy_st[i-1] = rdy_st[i];
        end
        rdy_n--;
    endfunction

    function automatic bit yield_current();
        logic [9:0] id;
        logic [5:0] pr;
        logic [31:0] st;
        slice_cnt = 0;
        if (cur_idle) begin
            if (rdy_n == 0) return 0;
            dispatch_head();
            return 1;
        end
        if (rdy_n == 0 || ranks_ahead(cur_pr, cur_st, rdy_pr[0], rdy_st[0])) return 0;
        id = cur_id; pr = cur_pr; st = cur_st;
        dispatch_head();
        void'(ready_push(id, pr, st));
        return 1;
    endfunction

    function automatic answer_t schedule_request(req_type_t rt, logic [9:0] id,
                                                 logic [5:0] pr, logic [31:0] bs,
                                                 logic [31:0] tv);
        answer_t a;
        bit sw, pre, woke;
        logic [1:0] st;
        int j;
        sw = 0; pre = 0; st = STAT_OK;
        case (rt)
            REQ_MAKE_READY: begin
                if (!ready_push(id, pr, bs)) st = STAT_FULL;
                else pre = cur_idle || pr > cur_pr;
            end
            REQ_YIELD: sw = yield_current();
            REQ_BLOCK, REQ_EXIT: begin
                if (cur_idle) st = STAT_INVAL;
                else begin
                    dispatch_head();
                    sw = 1;
                end
            end
            REQ_SLEEP: begin
                if (cur_idle) st = STAT_INVAL;
                else if (!sleep_push(tv)) st = STAT_FULL;
                else begin
                    dispatch_head();
                    sw = 1;
                end
            end
            REQ_TICK: begin
                j = 0;
                for (int i = 0; i < slp_n; i++) begin
                    woke = 0;
                    if (slp_wk[i] <= tv) begin
                        woke = ready_push(slp_id[i], slp_pr[i], slp_st[i]);
                        if (!woke) st = STAT_FULL;
                        else if (!cur_idle && slp_pr[i] > cur_pr) pre = 1;
                    end
                    if (!woke) begin
                        slp_id[j] = slp_id[i]; slp_pr[j] = slp_pr[i];
                        slp_st[j] = slp_st[i]; slp_wk[j] = slp_wk[i];
                        j++;
                    end
                end
                slp_n = j;
                if (cur_idle && rdy_n > 0) pre = 1;
                if (slice_cnt != 8'hFF) slice_cnt++;
                if (slice_cnt >= slice_len) pre = 1;
            end
            REQ_SET_PRIO: begin
                if (cur_idle) st = STAT_INVAL;
                else begin
                    cur_pr = pr;
                    if (rdy_n > 0 && rdy_pr[0] > cur_pr) sw = yield_current();
                end
            end
            default: ;
        endcase
        a.run_id = cur_idle ? 10'd0 : cur_id;
        a.run_idle = cur_idle;
        a.switched = sw;
        a.preempt_req = pre;
        a.status = st;
        a.ready_count = 5'(rdy_n);
        a.sleep_count = 5'(slp_n);
        return a;
    endfunction

    // valid stays up after an accept; the next request or the idle gap replaces it
    task automatic send_request(req_type_t rt, logic [9:0] id, logic [5:0] pr,
                                logic [31:0] bs, logic [31:0] tv);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= {tv, bs, pr, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        answer_q.push_back(schedule_request(rt, id, pr, bs, tv));
    endtask

    task automatic send_random(int pct_tick);
        req_type_t rt;
        int r;
        r = $urandom_range(99);
        if (r < 30) rt = REQ_MAKE_READY;
        else if (r < 30 + pct_tick) rt = REQ_TICK;
        else rt = req_type_t'($urandom_range(7));
        if (rt == REQ_TICK) now_tick += $urandom_range(8);
        send_request(rt, 10'($urandom), 6'($urandom),
                     ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(7)),
                     ($urandom_range(19) == 0) ? $urandom
                                               : now_tick + $urandom_range(12));
    endtask

    task automatic drain_answers();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_slice(logic [7:0] v);
        drain_answers();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        slice_len = v;
    endtask

    task automatic test_directed();
        send_request(REQ_BLOCK, 0, 0, 0, 0);
        send_request(REQ_SLEEP, 0, 0, 0, 5);
        send_request(REQ_EXIT, 0, 0, 0, 0);
        send_request(REQ_SET_PRIO, 0, 63, 0, 0);
        send_request(REQ_YIELD, 0, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0, 0);
        send_request(REQ_UNUSED, 10'h3FF, 6'h3F, '1, '1);
        send_request(REQ_MAKE_READY, 10'h3FF, 6'h3F, '1, 0);
        send_request(REQ_MAKE_READY, 10'h001, 6'h3F, '1, 0);
        send_request(REQ_MAKE_READY, 10'h002, 6'h3F, 32'd0, 0);
        send_request(REQ_MAKE_READY, 10'h000, 6'h00, 32'd0, '1);
        send_request(REQ_YIELD, 0, 0, 0, 0);
        send_request(REQ_YIELD, 0, 0, 0, 0);
        send_request(REQ_SLEEP, 0, 0, 0, 32'd10);
        send_request(REQ_SLEEP, 0, 0, 0, '1);
        send_request(REQ_TICK, 0, 0, 0, 32'd9);
        send_request(REQ_TICK, 0, 0, 0, 32'd10);
        send_request(REQ_SET_PRIO, 0, 6'h00, 0, 0);
        send_request(REQ_SET_PRIO, 0, 6'h3F, 0, 0);
        send_request(REQ_BLOCK, 0, 0, 0, 0);
        send_request(REQ_EXIT, 0, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0, '1);
    endtask

    // fill both stores past capacity, then wake sleepers into a full ready store
    task automatic test_full_stores();
        for (int i = 0; i < 18; i++)
            send_request(REQ_MAKE_READY, 10'(i + 100), 6'($urandom), 32'($urandom_range(3)), 0);
        for (int i = 0; i < 18; i++)
            send_request(REQ_SLEEP, 0, 0, 0, 32'($urandom_range(4)));
        for (int i = 0; i < 18; i++)
            send_request(REQ_MAKE_READY, 10'(i + 200), 6'($urandom), 32'($urandom), 0);
        send_request(REQ_YIELD, 0, 0, 0, 0);
        send_request(REQ_SET_PRIO, 0, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0, '1);
        for (int i = 0; i < 20; i++) send_request(REQ_EXIT, 0, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0, '1);
        for (int i = 0; i < 20; i++) send_request(REQ_BLOCK, 0, 0, 0, 0);
        now_tick = 0;
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_random(25);
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (200) @(posedge aclk);
                rx_hold = 0;
            end
            for (int i = 0; i < 30; i++) send_random(20);
        join
        drain_answers();
    endtask

    task automatic test_no_idle(int count);
        idle_pct = 0;
        for (int i = 0; i < count; i++) send_random(25);
        idle_pct = 33;
    endtask

    // result side: random stalls and field-by-field compare against the oldest entry
    always @(posedge aclk) begin
        answer_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.run_id      = m_tdata[9:0];
                got.run_idle    = m_tdata[10];
                got.switched    = m_tdata[11];
                got.preempt_req = m_tdata[12];
                got.status      = m_tdata[14:13];
                got.ready_count = m_tdata[19:15];
                got.sleep_count = m_tdata[24:20];
                answers_seen++;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected answer %h", $time, m_tdata);
                    fail_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want || m_tdata[31:25] !== 7'd0) begin
                        $display("%0t: mismatch expected id=%0d idle=%0b sw=%0b",
                                 $time, want.run_id, want.run_idle, want.switched,
                                 " pre=%0b st=%0d rdy=%0d slp=%0d",
                                 want.preempt_req, want.status, want.ready_count,
                                 want.sleep_count);
                        $display("%0t: mismatch actual   id=%0d idle=%0b sw=%0b",
                                 $time, got.run_id, got.run_idle, got.switched,
                                 " pre=%0b st=%0d rdy=%0d slp=%0d pad=%h",
                                 got.preempt_req, got.status, got.ready_count,
                                 got.sleep_count, m_tdata[31:25]);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= !rx_hold && !(idle_pct > 0 && $urandom_range(99) < idle_pct);
        end
    end

    // watchdog on cycles without any accepted request or answer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        rdy_n = 0; slp_n = 0; cur_id = 0; cur_pr = 0; cur_st = 0;
        cur_idle = 1; slice_cnt = 0; slice_len = 8'd4;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_slice(8'd1);
        test_full_stores();
        write_slice(8'd255);
        test_random(120);
        write_slice(8'd0);
        test_backpressure();
        write_slice(8'd3);
        test_no_idle(80);
        drain_answers();
        write_slice(8'($urandom_range(2, 8)));
        test_random(50);
        drain_answers();
        $display("Covered %0d answers: directed corners, full stores, slice settings,",
                 answers_seen);
        $display("a long receiver hold-off and random request mixes with random stalls.");
        if (fail_cnt == 0 && answer_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
